/* design/rmmst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmmst_pkg: shared types and constants of the range min/max segment tree
// Command and result formats, node pair type, identity values and the
// node merge function used by the tree walks.
// ----------------------------------------------------------------------------
package rmmst_pkg;

   // field widths fixed by the interface
   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int CFG_W = 11;

   // size register reset value
   localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // extreme values
   localparam logic signed [VAL_W-1:0] INT_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] INT_MIN   = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] BAD_VALUE = -32'sd1;

   // one tree node: minimum and maximum of its span
   typedef struct packed {
      logic signed [VAL_W-1:0] mn;
      logic signed [VAL_W-1:0] mx;
   } node_type;

   localparam node_type NODE_IDENTITY = '{mn: INT_MAX, mx: INT_MIN};

   // classified command from the front to the back
   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_BAD    = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type              op;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        range_low;
      logic [POS_W-1:0]        range_high;
   } cmd_type;

   // result transaction
   typedef struct packed {
      logic signed [VAL_W-1:0] range_min;
      logic signed [VAL_W-1:0] range_max;
      logic                    status;
   } rsp_type;

   localparam rsp_type BAD_RESULT = '{range_min: BAD_VALUE, range_max: BAD_VALUE,
                                      status: STATUS_BAD};

   // combine two node pairs
   function automatic node_type node_merge(input node_type a, input node_type b);
      node_type m;
      m.mn = (b.mn < a.mn) ? b.mn : a.mn;
      m.mx = (b.mx > a.mx) ? b.mx : a.mx;
      return m;
   endfunction

endpackage
`default_nettype wire

/* design/rmmst_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmmst_fifo: small register queue
// Holds up to DEPTH entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rmmst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* design/rmmst_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmmst_front: input side of the segment tree
// Holds the size register, bounds-checks each item, drops out-of-range
// writes and queues classified commands for the back end.
// ----------------------------------------------------------------------------
module rmmst_front #(
   parameter int LEAF_COUNT = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic                             req_kind,
   input  wire logic [rmmst_pkg::POS_W-1:0]      req_position,
   input  wire logic signed [rmmst_pkg::VAL_W-1:0] req_value,
   input  wire logic [rmmst_pkg::POS_W-1:0]      req_range_low,
   input  wire logic [rmmst_pkg::POS_W-1:0]      req_range_high,
   input  wire logic                             csr_wr_en,
   input  wire logic [rmmst_pkg::CFG_W-1:0]      csr_wr_data,
   input  wire logic                             clear_busy,
   input  wire logic                             cmd_pop,
   output logic                                  cmd_empty,
   output rmmst_pkg::cmd_type                    cmd_data
);
   import rmmst_pkg::*;

   localparam int LCW = $clog2(LEAF_COUNT) + 1;
   localparam int SW  = (CFG_W > LCW) ? CFG_W : LCW;

   logic [CFG_W-1:0]          size_ff;
   logic [SW-1:0]             eff_size;
   logic [SW-1:0]             pos_ext, hi_ext;
   logic                      accepted, cmd_full, cmd_push;
   logic                      write_oob, query_bad;
   cmd_type                   cmd_in;
   logic [$bits(cmd_type)-1:0] cmd_word;

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // bounds checks against the size saturated to the leaf count
   assign eff_size  = (SW'(size_ff) > SW'(LEAF_COUNT)) ? SW'(LEAF_COUNT) : SW'(size_ff);
   assign pos_ext   = SW'(req_position);
   assign hi_ext    = SW'(req_range_high);
   assign write_oob = (pos_ext >= eff_size);
   assign query_bad = (req_range_low > req_range_high) || (hi_ext >= eff_size);

   // classify the transaction
   assign accepted = req_push && !req_full;
   assign cmd_push = accepted && !((req_kind == KIND_WRITE) && write_oob);

   always_comb begin
      cmd_in.position   = req_position;
      cmd_in.value      = req_value;
      cmd_in.range_low  = req_range_low;
      cmd_in.range_high = req_range_high;
      if (req_kind == KIND_WRITE) begin
         cmd_in.op = CMD_UPDATE;
      end else if (query_bad) begin
         cmd_in.op = CMD_BAD;
      end else begin
         cmd_in.op = CMD_QUERY;
      end
   end

   assign req_full = cmd_full || clear_busy;

   // command queue to the back end
   rmmst_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_word),
      .empty     (cmd_empty)
   );

   assign cmd_data = cmd_type'(cmd_word);

endmodule
`default_nettype wire

/* design/rmmst_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmmst_back: tree store and walk sequencer
// Owns the node memory, clears it after reset, runs leaf-to-root updates
// and bottom-up range queries one tree level per cycle.
// ----------------------------------------------------------------------------
module rmmst_back #(
   parameter int LEAF_COUNT = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   output logic                    clear_busy,
   input  wire logic               cmd_empty,
   input  wire rmmst_pkg::cmd_type cmd_data,
   output logic                    cmd_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output rmmst_pkg::rsp_type      rsp_data
);
   import rmmst_pkg::*;

   localparam int AW    = $clog2(LEAF_COUNT) + 1;   // node address bits
   localparam int NODES = 2 * LEAF_COUNT;
   localparam int LW    = AW + 1;                   // query bound bits
   localparam logic [AW-1:0] ROOT_NODE = AW'(1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_UPD   = 5'b00100,
      S_QRY   = 5'b01000,
      S_QFIN  = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   cur_ff, cur_in;
   node_type        val_ff, val_in;
   logic [LW-1:0]   l_ff, l_in, r_ff, r_in;
   node_type        acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic            rd_l_vld_ff, rd_l_vld_in, rd_r_vld_ff, rd_r_vld_in;

   node_type        tree_mem [NODES];
   node_type        rd_a_ff, rd_b_ff;
   logic            wr_en, rd_a_en, rd_b_en;
   logic [AW-1:0]   wr_addr, rd_a_addr, rd_b_addr;
   node_type        wr_data;

   logic [AW-1:0]   leaf_addr, upd_parent;
   logic [LW-1:0]   q_low, q_high_end, r_dec;
   node_type        upd_merged, q_merged, leaf_pair;

   // tree walk helpers
   assign leaf_addr  = AW'(LEAF_COUNT) + AW'(cmd_data.position);
   assign leaf_pair  = '{mn: cmd_data.value, mx: cmd_data.value};
   assign upd_parent = cur_ff >> 1;
   assign upd_merged = node_merge(val_ff, rd_a_ff);
   assign q_low      = LW'(LEAF_COUNT) + LW'(cmd_data.range_low);
   assign q_high_end = LW'(LEAF_COUNT) + LW'(cmd_data.range_high) + LW'(1);
   assign r_dec      = r_ff - LW'(1);
   assign q_merged   = node_merge(acc_l_ff, acc_r_ff);
   assign clear_busy = (state_ff == S_CLEAR);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      val_in      = val_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      acc_l_in    = acc_l_ff;
      acc_r_in    = acc_r_ff;
      rd_l_vld_in = 1'b0;
      rd_r_vld_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = upd_parent;
      wr_data     = upd_merged;
      rd_a_en     = 1'b0;
      rd_a_addr   = l_ff[AW-1:0];
      rd_b_en     = 1'b0;
      rd_b_addr   = r_dec[AW-1:0];
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = BAD_RESULT;

      // fold read data issued in the previous query cycle
      if (rd_l_vld_ff) begin
         acc_l_in = node_merge(acc_l_ff, rd_a_ff);
      end
      if (rd_r_vld_ff) begin
         acc_r_in = node_merge(acc_r_ff, rd_b_ff);
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = NODE_IDENTITY;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_data.op)
                  CMD_UPDATE: begin
                     // set the leaf, fetch its sibling
                     cmd_pop   = 1'b1;
                     wr_en     = 1'b1;
                     wr_addr   = leaf_addr;
                     wr_data   = leaf_pair;
                     cur_in    = leaf_addr;
                     val_in    = leaf_pair;
                     rd_a_en   = 1'b1;
                     rd_a_addr = leaf_addr ^ AW'(1);
                     state_in  = S_UPD;
                  end
                  CMD_QUERY: begin
                     // result slot is reserved before the walk starts
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        l_in     = q_low;
                        r_in     = q_high_end;
                        acc_l_in = NODE_IDENTITY;
                        acc_r_in = NODE_IDENTITY;
                        state_in = S_QRY;
                     end
                  end
                  CMD_BAD: begin
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data = BAD_RESULT;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         S_UPD: begin
            // write parent from running pair and sibling, fetch next sibling
            wr_en  = 1'b1;
            cur_in = upd_parent;
            val_in = upd_merged;
            if (upd_parent == ROOT_NODE) begin
               state_in = S_IDLE;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = upd_parent ^ AW'(1);
            end
         end
         S_QRY: begin
            // issue boundary reads for this level, then climb
            if (l_ff < r_ff) begin
               rd_a_en     = l_ff[0];
               rd_l_vld_in = l_ff[0];
               rd_b_en     = r_ff[0];
               rd_r_vld_in = r_ff[0];
               l_in        = (l_ff + LW'(l_ff[0])) >> 1;
               r_in        = r_ff >> 1;
            end else begin
               state_in = S_QFIN;
            end
         end
         S_QFIN: begin
            rsp_push           = 1'b1;
            rsp_data.range_min = q_merged.mn;
            rsp_data.range_max = q_merged.mx;
            rsp_data.status    = STATUS_OK;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         rd_l_vld_ff <= 1'b0;
         rd_r_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_l_vld_ff <= rd_l_vld_in;
         rd_r_vld_ff <= rd_r_vld_in;
      end
   end

   // walk payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      val_ff   <= val_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
   end

   // node memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= tree_mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= tree_mem[rd_b_addr];
      end
   end

   // checks
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !cmd_pop)
      else $error("command taken during clearing pass");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_fold_in_query: assert property (@(posedge clock) disable iff (reset)
      (rd_l_vld_ff || rd_r_vld_ff) |-> (state_ff == S_QRY))
      else $error("query read data lands outside the query walk");

   a_upd_below_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (cur_ff != ROOT_NODE))
      else $error("update walk climbed past the root");

endmodule
`default_nettype wire

/* design/range_min_max_segment_tree.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// range_min_max_segment_tree: range minimum/maximum segment tree
// Keeps min/max pairs over LEAF_COUNT signed elements; point writes and
// inclusive range queries through queue-style ports.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every node of the node
// memory, holding req_full high (size writes are taken meanwhile). A write
// in range walks from its leaf to the root in the back end and gives no
// result; an out-of-range write is dropped at the input. A valid query walks
// up the tree from both of its bounds; a reversed or overlong query returns
// status 1 without a walk. The walks climb one tree level per cycle, a query
// using both read ports of the node memory. A two-entry command queue and a
// two-entry result queue let input and output stall independently of the walk.
module range_min_max_segment_tree #(
   parameter int LEAF_COUNT = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_kind,
   input  wire logic [rmmst_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [rmmst_pkg::VAL_W-1:0]  req_value,
   input  wire logic [rmmst_pkg::POS_W-1:0]         req_range_low,
   input  wire logic [rmmst_pkg::POS_W-1:0]         req_range_high,
   input  wire logic                                rsp_pop,
   output logic                                     rsp_empty,
   output logic signed [rmmst_pkg::VAL_W-1:0]       rsp_range_min,
   output logic signed [rmmst_pkg::VAL_W-1:0]       rsp_range_max,
   output logic                                     rsp_status,
   input  wire logic                                csr_wr_en,
   input  wire logic [rmmst_pkg::CFG_W-1:0]         csr_wr_data
);
   import rmmst_pkg::*;

   logic                       clear_busy;
   logic                       cmd_empty, cmd_pop;
   cmd_type                    cmd_data;
   logic                       rsp_full, rsp_push;
   rsp_type                    rsp_in, rsp_out;
   logic [$bits(rsp_type)-1:0] rsp_word;

   // front: size register, classification, command queue
   rmmst_front #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .clear_busy     (clear_busy),
      .cmd_pop        (cmd_pop),
      .cmd_empty      (cmd_empty),
      .cmd_data       (cmd_data)
   );

   // back: node memory and tree walks
   rmmst_back #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .cmd_empty  (cmd_empty),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in)
   );

   // result queue
   rmmst_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_word),
      .empty     (rsp_empty)
   );

   assign rsp_out       = rsp_type'(rsp_word);
   assign rsp_range_min = rsp_out.range_min;
   assign rsp_range_max = rsp_out.range_max;
   assign rsp_status    = rsp_out.status;

endmodule
`default_nettype wire

/* bench/range_min_max_segment_tree_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_min_max_segment_tree_tb: self-checking bench for the min/max tree
// Drives point writes and range queries through the request queue and
// predicts each query answer from a flat element array. Answers are checked
// field by field in order. The size register is moved between phases, and
// both sides of the block are stalled at random.
// ----------------------------------------------------------------------------
module range_min_max_segment_tree_tb;
   import rmmst_pkg::*;

   localparam int LEAF_COUNT  = 1024;
   localparam int SETTLE_CYC  = 64;      // back-end drain before size write / end
   localparam int STALL_LIMIT = 20000;   // covers the clearing pass after reset

   logic                    clock;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic                    req_kind;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_value;
   logic [POS_W-1:0]        req_range_low;
   logic [POS_W-1:0]        req_range_high;
   logic                    rsp_pop;
   logic                    rsp_empty;
   logic signed [VAL_W-1:0] rsp_range_min;
   logic signed [VAL_W-1:0] rsp_range_max;
   logic                    rsp_status;
   logic                    csr_wr_en;
   logic [CFG_W-1:0]        csr_wr_data;

   // mirror of the element store and the size register
   node_type         elem_pair [LEAF_COUNT];
   logic [CFG_W-1:0] mirror_size;

   rsp_type pending_answers[$];
   int      mismatch_count;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      stall_cycles;

   range_min_max_segment_tree #(.LEAF_COUNT(LEAF_COUNT)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_range_min  (rsp_range_min),
      .rsp_range_max  (rsp_range_max),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // bounds checks use the size saturated to the leaf count
   function automatic int active_size();
      return (mirror_size > LEAF_COUNT) ? LEAF_COUNT : int'(mirror_size);
   endfunction

   // min/max over an inclusive range of the mirror, or the bad-range answer
   function automatic rsp_type range_answer(input int lo, input int hi);
      rsp_type a;
      if (lo > hi || hi >= active_size()) begin
         a.range_min = BAD_VALUE;
         a.range_max = BAD_VALUE;
         a.status    = STATUS_BAD;
         return a;
      end
      a.range_min = INT_MAX;
      a.range_max = INT_MIN;
      a.status    = STATUS_OK;
      for (int i = lo; i <= hi; i++) begin
         if (elem_pair[i].mn < a.range_min) a.range_min = elem_pair[i].mn;
         if (elem_pair[i].mx > a.range_max) a.range_max = elem_pair[i].mx;
      end
      return a;
   endfunction

   // update the mirror for one accepted transaction
   task automatic tree_apply(input logic kind, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
      if (kind == KIND_WRITE) begin
         if (int'(pos) < active_size()) begin
            elem_pair[pos].mn = val;
            elem_pair[pos].mx = val;
         end
      end else begin
         pending_answers.push_back(range_answer(int'(lo), int'(hi)));
      end
   endtask

   // one request transaction; entered and left at a falling edge, push left high
   task automatic send_item(input logic kind, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val,
                            input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_position   <= pos;
      req_value      <= val;
      req_range_low  <= lo;
      req_range_high <= hi;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tree_apply(kind, pos, val, lo, hi);
      @(negedge clock);
   endtask

   // unused fields carry random bits
   task automatic put_elem(input int pos, input logic signed [VAL_W-1:0] val);
      send_item(KIND_WRITE, pos[POS_W-1:0], val, POS_W'($urandom), POS_W'($urandom));
   endtask

   task automatic ask_range(input int lo, input int hi);
      send_item(KIND_QUERY, POS_W'($urandom), $urandom, lo[POS_W-1:0], hi[POS_W-1:0]);
   endtask

   // size write only with the block idle
   task automatic set_size(input int sz);
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sz[CFG_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mirror_size = sz[CFG_W-1:0];
   endtask

   task automatic test_empty_tree();
      ask_range(0, LEAF_COUNT - 1);
      ask_range(5, 5);
   endtask

   task automatic test_extremes();
      put_elem(0, INT_MIN);
      put_elem(LEAF_COUNT - 1, INT_MAX);
      put_elem('h2AA, 32'sh5555_5555);
      put_elem('h155, 32'shAAAA_AAAA);
      put_elem(512, BAD_VALUE);
      put_elem(511, 0);
      ask_range(0, LEAF_COUNT - 1);
      ask_range(0, 0);
      ask_range(LEAF_COUNT - 1, LEAF_COUNT - 1);
      ask_range('h155, 'h2AA);
      ask_range(700, LEAF_COUNT - 2);        // only unwritten leaves
      ask_range(1, 0);                       // reversed
      ask_range(LEAF_COUNT - 1, 0);          // reversed
      put_elem(0, 7);                        // overwrite
      ask_range(0, 511);
   endtask

   task automatic test_size_limits();
      set_size(1);
      put_elem(0, -5);
      put_elem(1, 9);                        // beyond size, dropped
      ask_range(0, 0);
      ask_range(0, 1);                       // runs past size
      set_size(0);
      put_elem(0, 3);                        // every write dropped
      ask_range(0, 0);
      set_size(2047);                        // saturates to the leaf count
      ask_range(0, LEAF_COUNT - 1);
      set_size(2);
      ask_range(1, 1);
      ask_range(0, 2);
   endtask

   // random items until the given number of effective transactions is sent
   task automatic run_random_items(input int target);
      int   sent;
      int   n;
      int   pick;
      int   lo;
      int   hi;
      logic signed [VAL_W-1:0] val;
      sent = 0;
      while (sent < target) begin
         n    = active_size();
         pick = $urandom_range(99);
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(9))
               0:       val = INT_MAX;
               1:       val = INT_MIN;
               2:       val = BAD_VALUE;
               3:       val = 0;
               default: val = $urandom;
            endcase
            if (pick < 88 && n > 0) lo = $urandom_range(n - 1);
            else lo = $urandom_range(LEAF_COUNT - 1);
            if (lo < n) sent++;
            put_elem(lo, val);
         end else begin
            if (pick < 75 && n > 0) begin
               lo = $urandom_range(n - 1);
               if ($urandom_range(3) == 0) hi = lo;
               else hi = $urandom_range(n - 1, lo);
            end else if (pick < 85) begin
               hi = $urandom_range(LEAF_COUNT - 2);
               lo = $urandom_range(LEAF_COUNT - 1, hi + 1);
            end else begin
               lo = $urandom_range(LEAF_COUNT - 1);
               hi = $urandom_range(LEAF_COUNT - 1);
            end
            sent++;
            ask_range(lo, hi);
         end
      end
   endtask

   // three size settings under one stall profile
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int top_size);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_size($urandom_range(16, 1));
      run_random_items(70);
      set_size($urandom_range(1023, 17));
      run_random_items(70);
      set_size(top_size);
      run_random_items(70);
   endtask

   // receiver side: pop at random per the current profile
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each popped answer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            $error("unexpected answer: range_min %0d range_max %0d status %0d",
                   rsp_range_min, rsp_range_max, rsp_status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_range_min !== want.range_min) begin
               mismatch_count++;
               $error("range_min: expected %0d, actual %0d", want.range_min,
                      rsp_range_min);
            end
            if (rsp_range_max !== want.range_max) begin
               mismatch_count++;
               $error("range_max: expected %0d, actual %0d", want.range_max,
                      rsp_range_max);
            end
            if (rsp_status !== want.status) begin
               mismatch_count++;
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
            end
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_kind       = KIND_WRITE;
      req_position   = '0;
      req_value      = '0;
      req_range_low  = '0;
      req_range_high = '0;
      rsp_pop        = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      stall_cycles   = 0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      mirror_size    = SIZE_RESET;
      for (int i = 0; i < LEAF_COUNT; i++) elem_pair[i] = NODE_IDENTITY;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_empty_tree();
      test_extremes();
      test_size_limits();
      test_random_traffic(37, 69, LEAF_COUNT);
      test_random_traffic(69, 37, $urandom_range(2047, LEAF_COUNT + 1));
      test_random_traffic(0, 0, LEAF_COUNT);

      // drain, then give stray answers a chance to show up
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* range_min_max_segment_tree.f */
design/rmmst_pkg.sv
design/rmmst_fifo.sv
design/rmmst_front.sv
design/rmmst_back.sv
design/range_min_max_segment_tree.sv
bench/range_min_max_segment_tree_tb.sv
